### rtl/core/ewa_pkg.sv
package ewa_pkg;

    localparam int HIST_DEPTH  = 5;
    localparam int COUNT_W     = 16;
    localparam int WEIGHT_W    = 3;
    localparam int PROD_W      = 19;
    localparam int SUM_W       = 21;
    localparam int MAG_W       = 20;
    localparam int SPEED_W     = 13;
    localparam int PERIOD_W    = 8;
    localparam int DIVISOR     = 210;
    localparam int RECIP_SHIFT = 28;
    localparam int RECIP_MULT  = ((2 ** RECIP_SHIFT) + DIVISOR - 1) / DIVISOR;
    localparam int RECIP_W     = 21;
    localparam int RPROD_W     = MAG_W + RECIP_W;

    // Per-stage control that travels with each word
    typedef struct packed {
        logic valid;
        logic taken;
    } t_ctl;

    // Weight of the cell at age k: newest gets HIST_DEPTH + 1
    function automatic logic [WEIGHT_W-1:0] f_weight(input int k);
        return WEIGHT_W'(HIST_DEPTH + 1 - k);
    endfunction

endpackage

### rtl/core/encoder_speed_weighted_average.sv
// Channel   Dir  Handshake                          Word
// s_axis    in   i_s_axis_tvalid / o_s_axis_tready  tdata[15:0] encoder_count
// m_axis    out  o_m_axis_tvalid / i_m_axis_tready  tdata[12:0] speed, tuser sample_taken
// cfg       in   i_cfg_valid / o_cfg_ready          i_cfg_data sample_period
//
// One word in and one word out per cycle unless m_axis stalls; the stages are
// counter and cell row, weighted sum, reciprocal multiply, output register.
// Reset (synchronous, active low) clears the cell row, the tick counter and
// the held speed, and sets sample_period to 1.
// A stall on m_axis freezes the whole pipe; s_axis stays ready as long as the
// output register is empty or being drained.
module encoder_speed_weighted_average (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [15:0] encoder_count
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [12:0] speed, [15:13] zero
    output logic        o_m_axis_tuser,   // [0] sample_taken
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data        // sample_period
);
    import ewa_pkg::*;

    logic                       w_adv;
    logic                       w_accept;
    logic                       w_take;
    logic                       w_shift;

    logic [PERIOD_W-1:0]        r_period;
    logic [PERIOD_W-1:0]        r_tick;
    logic [PERIOD_W-1:0]        n_tick;

    t_ctl                       r_s0;
    t_ctl                       r_s1;
    t_ctl                       r_s2;
    t_ctl                       r_out;
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [SUM_W-1:0]    n_sum;
    logic signed [SPEED_W-1:0]  w_quot;
    logic signed [SPEED_W-1:0]  r_held;
    logic signed [SPEED_W-1:0]  n_held;
    logic signed [SPEED_W-1:0]  r_speed;

    logic signed [COUNT_W-1:0]  w_chain [HIST_DEPTH+1];
    logic signed [PROD_W-1:0]   w_prod  [HIST_DEPTH];

    // Whole pipe advances together whenever the output register can move
    assign w_adv           = !r_out.valid || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;
    assign w_accept        = i_s_axis_tvalid && w_adv;
    assign o_cfg_ready     = 1'b1;

    // Sample tick: counter matches the period before it advances
    assign w_take  = (r_tick == r_period);
    assign w_shift = w_accept && w_take;
    assign n_tick  = w_take ? PERIOD_W'(1) : r_tick + PERIOD_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_W'(1);
            r_tick   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_period <= i_cfg_data;
            end
            if (w_accept) begin
                r_tick <= n_tick;
            end
        end
    end

    // Row of history cells: cell 0 holds the newest sample
    assign w_chain[0] = $signed(i_s_axis_tdata);

    for (genvar g = 0; g < HIST_DEPTH; g++) begin : g_cell
        ewa_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (w_shift),
            .i_sample (w_chain[g]),
            .i_weight (f_weight(g)),
            .o_sample (w_chain[g+1]),
            .o_prod   (w_prod[g])
        );
    end

    // Sum the weighted cell outputs; the row is settled for the word in stage 0
    always_comb begin
        n_sum = '0;
        for (int k = 0; k < HIST_DEPTH; k++) begin
            n_sum = n_sum + SUM_W'(w_prod[k]);
        end
    end

    ewa_recip u_recip (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_sum  (r_sum),
        .o_quot (w_quot)
    );

    // Update the held speed only when a sample word leaves stage 2
    assign n_held = r_s2.taken ? w_quot : r_held;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0   <= '0;
            r_s1   <= '0;
            r_s2   <= '0;
            r_out  <= '0;
            r_held <= '0;
        end else if (w_adv) begin
            r_s0.valid <= w_accept;
            r_s0.taken <= w_shift;
            r_s1       <= r_s0;
            r_s2       <= r_s1;
            r_out      <= r_s2;
            if (r_s2.valid) begin
                r_held <= n_held;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sum   <= n_sum;
            r_speed <= n_held;
        end
    end

    assign o_m_axis_tvalid = r_out.valid;
    assign o_m_axis_tuser  = r_out.taken;
    assign o_m_axis_tdata  = {{(16-SPEED_W){1'b0}}, r_speed};

endmodule

### rtl/core/ewa_cell.sv
module ewa_cell (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_shift,
    input  logic signed [ewa_pkg::COUNT_W-1:0]   i_sample,
    input  logic        [ewa_pkg::WEIGHT_W-1:0]  i_weight,
    output logic signed [ewa_pkg::COUNT_W-1:0]   o_sample,
    output logic signed [ewa_pkg::PROD_W-1:0]    o_prod
);
    import ewa_pkg::*;

    logic signed [COUNT_W-1:0] r_sample;
    logic signed [COUNT_W-1:0] n_sample;
    logic signed [PROD_W-1:0]  w_sext;
    logic signed [PROD_W-1:0]  w_wext;

    // Take the neighbor's sample on a shift, otherwise hold
    assign n_sample = i_shift ? i_sample : r_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
        end else begin
            r_sample <= n_sample;
        end
    end

    assign w_sext   = PROD_W'(r_sample);
    assign w_wext   = $signed({{(PROD_W-WEIGHT_W){1'b0}}, i_weight});
    assign o_prod   = w_sext * w_wext;
    assign o_sample = r_sample;

endmodule

### rtl/core/ewa_recip.sv
module ewa_recip (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [ewa_pkg::SUM_W-1:0]    i_sum,
    output logic signed [ewa_pkg::SPEED_W-1:0]  o_quot
);
    import ewa_pkg::*;

    logic [RPROD_W-1:0] r_prod;
    logic [RPROD_W-1:0] n_prod;
    logic               r_neg;
    logic [SUM_W-1:0]   w_abs;
    logic [SPEED_W-1:0] w_mag_q;

    // Divide the magnitude by multiplying with the rounded-up reciprocal
    assign w_abs  = i_sum[SUM_W-1] ? SUM_W'(-i_sum) : SUM_W'(i_sum);
    assign n_prod = RPROD_W'(w_abs[MAG_W-1:0]) * RPROD_W'(RECIP_MULT);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_neg  <= i_sum[SUM_W-1];
        end
    end

    // Restore the sign: truncation toward zero
    assign w_mag_q = r_prod[RECIP_SHIFT +: SPEED_W];
    assign o_quot  = r_neg ? $signed(-w_mag_q) : $signed(w_mag_q);

endmodule

### rtl/core/ewa_checker.sv
module ewa_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_s_axis_tready,
    input  logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [15:0] o_m_axis_tdata,
    input  logic        o_m_axis_tuser
);
    logic [12:0] r_last_speed;

    // Track the last speed delivered downstream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_speed <= '0;
        end else if (o_m_axis_tvalid && i_m_axis_tready) begin
            r_last_speed <= o_m_axis_tdata[12:0];
        end
    end

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output word dropped while stalled");

    a_stall_backs_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |-> !o_s_axis_tready)
        else $error("input ready while output stalled");

    a_speed_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata[12:0] == r_last_speed)
        else $error("speed changed on a non-sample word");

    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ($signed(o_m_axis_tdata[12:0]) >= -13'sd3120)
                         && ($signed(o_m_axis_tdata[12:0]) <= 13'sd3120))
        else $error("speed out of range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind encoder_speed_weighted_average ewa_checker u_ewa_checker (.*);
